// File: rtl/insertion_sorter_macros.svh
// Assertion macros for the insertion sorter.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold on every edge out of reset.
`define ISORT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("isort assertion failed");
// Condition must never be seen out of reset.
`define ISORT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("isort forbidden condition seen");
`else
`define ISORT_ASSERT(label, clk, rst_n, prop)
`define ISORT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies.
package isort_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] isort_data_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic insert;  // write value into the cell chain
    logic drain;   // shift the chain down by one place
  } isort_cmd_t;

endpackage

// File: rtl/isort_ctrl.sv
// Insertion sorter controller: fill/drain sequencing, element count, overflow flag.
// Depends on isort_pkg and insertion_sorter_macros.svh.
`include "insertion_sorter_macros.svh"

module isort_ctrl import isort_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            is_last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            is_last_res_o,
  output logic            overflow_o,
  output logic [CntW-1:0] count_o,
  output isort_cmd_t      cmd_o
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            in_acc, out_acc, full;

  assign in_ready_o  = (state_q == ST_FILL);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == CntFull);

  assign cmd_o.insert = in_acc && !full;
  assign cmd_o.drain  = out_acc;

  assign is_last_res_o = (count_q == CntOne);
  assign overflow_o    = ovf_q;
  assign count_o       = count_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntOne;
          end
          if (is_last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_d = count_q - CntOne;
          if (count_q == CntOne) begin
            state_d = ST_FILL;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  `ISORT_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntFull)
  `ISORT_ASSERT_NEVER(a_drain_empty, clk_i, rst_ni, out_valid_o && (count_q == '0))
  `ISORT_ASSERT(a_last_starts_drain, clk_i, rst_ni, (in_acc && is_last_i) |=> out_valid_o)
  `ISORT_ASSERT(a_ovf_only_full, clk_i, rst_ni, (ovf_q && in_ready_o) |-> full)

endmodule

// File: rtl/isort_dp.sv
// Insertion sorter datapath: chain of compare-and-shift cells holding the sorted set.
// Depends on isort_pkg.
module isort_dp import isort_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  isort_cmd_t      cmd_i,
  input  logic [CntW-1:0] count_i,
  input  isort_data_t     value_i,
  output isort_data_t     head_o
);

  isort_data_t cell_q [DEPTH];
  logic [DEPTH-1:0] gt;

  // Cells at or above the count are empty and behave as larger than anything.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign gt[i] = (CntW'(i) >= count_i) || (cell_q[i] > value_i);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isort_data_t cell_d;
    isort_data_t below;
    logic        below_gt;

    if (i == 0) begin : g_first
      assign below    = value_i;
      assign below_gt = 1'b0;
    end else begin : g_rest
      assign below    = cell_q[i-1];
      assign below_gt = gt[i-1];
    end

    isort_data_t above;
    if (i == DEPTH - 1) begin : g_top
      assign above = cell_q[i];
    end else begin : g_mid
      assign above = cell_q[i+1];
    end

    always_comb begin
      cell_d = cell_q[i];
      if (cmd_i.drain) begin
        cell_d = above;
      end else if (cmd_i.insert && gt[i]) begin
        cell_d = below_gt ? below : value_i;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d;
    end
  end

  assign head_o = cell_q[0];

endmodule

// File: rtl/insertion_sorter.sv
// Insertion sorter: one input item per cycle while filling; each item is inserted at once
// by the broadcast compare-and-shift cell chain. After the last item, the first result
// is shown the next cycle and results then leave one per cycle from the chain head
// while out_ready_i is high. Input is held off while a set drains.
// Reset (rst_ni, asynchronous, active low) clears the count, overflow flag and state;
// cell contents are not reset and are never read before being written.
module insertion_sorter import isort_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sorted_value_o,
  output logic               is_last_res_o,
  output logic               overflow_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  isort_cmd_t      cmd;
  logic [CntW-1:0] count;
  isort_data_t     head;

  isort_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_last_res_o(is_last_res_o),
    .overflow_o   (overflow_o),
    .count_o      (count),
    .cmd_o        (cmd)
  );

  isort_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .count_i(count),
    .value_i(value_i),
    .head_o (head)
  );

  assign sorted_value_o = head;

endmodule

// File: tb/insertion_sorter_test.sv
// Self-checking testbench for insertion_sorter: directed table then random sets.
// Depends on isort_pkg and the insertion_sorter RTL; results are checked in order
// against an in-bench stable-insertion predictor.
module insertion_sorter_test;
  import isort_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int NumItems = 110;
  localparam int CycleLimit = 200000;
  localparam int NumDirected = 21;
  localparam isort_data_t MinVal = 32'sh8000_0000;
  localparam isort_data_t MaxVal = 32'sh7fff_ffff;

  typedef struct {
    isort_data_t val;
    logic        last;
    logic        known;    // expectation typed in below
    isort_data_t exp_val;
  } stim_row_t;

  typedef struct {
    isort_data_t val;
    logic        last;
    logic        ovf;
  } sorted_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  isort_data_t value_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  isort_data_t sorted_value_o;
  logic        is_last_res_o;
  logic        overflow_o;

  isort_data_t held_vals[$];
  logic        dropped_any = 1'b0;
  sorted_res_t sorted_due[$];

  int cycle = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_sets = 0;
  int n_checked = 0;
  int n_ovf = 0;
  int burst_left = 1;

  // Single-element sets carry their own answer; the rest go through the predictor.
  stim_row_t directed [NumDirected] = '{
    '{MinVal, 1'b1, 1'b1, MinVal},
    '{MaxVal, 1'b1, 1'b1, MaxVal},
    '{32'sd0, 1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    '{MaxVal, 1'b0, 1'b0, '0},
    '{32'sd40, 1'b0, 1'b0, '0},
    '{-32'sd7, 1'b0, 1'b0, '0},
    '{MinVal, 1'b0, 1'b0, '0},
    '{-32'sd7, 1'b1, 1'b0, '0},
    '{MinVal, 1'b0, 1'b0, '0},
    '{-32'sd1, 1'b0, 1'b0, '0},
    '{32'sd0, 1'b0, 1'b0, '0},
    '{32'sd1, 1'b1, 1'b0, '0},
    '{32'sd5, 1'b0, 1'b0, '0},
    '{32'sd5, 1'b0, 1'b0, '0},
    '{32'sd5, 1'b0, 1'b0, '0},
    '{32'sd5, 1'b1, 1'b0, '0},
    '{32'sh4000_0000, 1'b0, 1'b0, '0},
    '{32'sh8000_0001, 1'b0, 1'b0, '0},
    '{32'sh7fff_fffe, 1'b0, 1'b0, '0},
    '{-32'sd2, 1'b1, 1'b0, '0}
  };

  insertion_sorter #(.DEPTH(Depth)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .is_last_res_o (is_last_res_o),
    .overflow_o    (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle, sorted_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: always ready, coin-flip stalls, one-in-four, rare stalls.
  always @(posedge clk_i) begin
    case ((cycle / 50) % 4)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(1));
      2:       out_ready_i <= (cycle % 4 == 0);
      default: out_ready_i <= ($urandom_range(7) != 0);
    endcase
  end

  // Stable insert: new value goes above every entry that is not greater than it.
  function automatic void predict_sort(input isort_data_t v, input logic last);
    int pos;
    sorted_res_t r;
    if (held_vals.size() < Depth) begin
      pos = held_vals.size();
      while (pos > 0 && held_vals[pos-1] > v) pos--;
      held_vals.insert(pos, v);
    end else begin
      dropped_any = 1'b1;
    end
    if (last) begin
      foreach (held_vals[k]) begin
        r.val  = held_vals[k];
        r.last = (k == held_vals.size() - 1);
        r.ovf  = dropped_any;
        sorted_due.push_back(r);
      end
      held_vals.delete();
      dropped_any = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    sorted_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_due.size() == 0) begin
        $error("unexpected result: sorted_value %0d", sorted_value_o);
        n_errors++;
      end else begin
        exp_res = sorted_due.pop_front();
        n_checked++;
        if (exp_res.ovf) n_ovf++;
        if (sorted_value_o !== exp_res.val) begin
          $error("sorted_value: expected %0d, got %0d", exp_res.val, sorted_value_o);
          n_errors++;
        end
        if (is_last_res_o !== exp_res.last) begin
          $error("is_last_res: expected %0b, got %0b", exp_res.last, is_last_res_o);
          n_errors++;
        end
        if (overflow_o !== exp_res.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_res.ovf, overflow_o);
          n_errors++;
        end
      end
    end
  end

  task automatic send_req(input isort_data_t v, input logic last);
    in_valid_i <= 1'b1;
    value_i    <= v;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    if (last) n_sets++;
  endtask

  // Bursts of 1..12 requests, then an idle gap on in_valid_i (often none).
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int n_rand;
    int set_len;
    int pick;
    isort_data_t v;
    n_rand = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_req(directed[i].val, directed[i].last);
      if (directed[i].known) sorted_due.push_back('{directed[i].exp_val, 1'b1, 1'b0});
      else predict_sort(directed[i].val, directed[i].last);
      pace();
    end

    // First random set overruns the store, last request included; then small sets.
    set_len = Depth + 3;
    while (n_rand < NumItems - NumDirected) begin
      for (int i = 0; i < set_len; i++) begin
        pick = $urandom_range(7);
        if (pick == 0) v = $urandom_range(1) ? MaxVal : MinVal;
        else if (pick < 3) v = $urandom_range(16) - 8;
        else v = $urandom;
        send_req(v, i == set_len - 1);
        predict_sort(v, i == set_len - 1);
        pace();
      end
      n_rand += set_len;
      set_len = $urandom_range(12, 1);
    end
    in_valid_i <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);

    $display("Sent %0d requests in %0d sets, checked %0d sorted results in order,",
             n_sent, n_sets, n_checked);
    $display("%0d of them from sets that overran the %0d-entry store.", n_ovf, Depth);
    if (n_errors == 0 && sorted_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
